@@ hdl/bsol_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsol_pkg
// Types, codes and the cost ordering shared by the bucketed open list files.
// ----------------------------------------------------------------------------
package bsol_pkg;

   localparam int COUNT_W = 13;

   // request commands
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_PEEK   = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;

   // result status codes
   localparam logic [2:0] STS_INSERTED = 3'd0;
   localparam logic [2:0] STS_REJECTED = 3'd1;
   localparam logic [2:0] STS_PEEKED   = 3'd2;
   localparam logic [2:0] STS_POPPED   = 3'd3;
   localparam logic [2:0] STS_EMPTY    = 3'd4;
   localparam logic [2:0] STS_FULL     = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  node_row;
      logic [7:0]  node_col;
      logic [3:0]  node_layer;
      logic [7:0]  parent_row;
      logic [7:0]  parent_col;
      logic [3:0]  parent_layer;
      logic [23:0] f_cost;
      logic [23:0] g_cost;
      logic [15:0] aux_value;
      logic [7:0]  turn_radius;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [COUNT_W-1:0] entry_count;
      logic [7:0]         out_row;
      logic [7:0]         out_col;
      logic [3:0]         out_layer;
      logic [7:0]         out_parent_row;
      logic [7:0]         out_parent_col;
      logic [3:0]         out_parent_layer;
      logic [23:0]        out_f;
      logic [23:0]        out_g;
      logic [15:0]        out_aux;
      logic [7:0]         out_radius;
   } rsp_type;

   // one stored list entry (row is implied by the bucket)
   typedef struct packed {
      logic [7:0]  col;
      logic [3:0]  layer;
      logic [7:0]  prow;
      logic [7:0]  pcol;
      logic [3:0]  player;
      logic [23:0] f;
      logic [23:0] g;
      logic [15:0] aux;
      logic [7:0]  radius;
   } ent_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INS_FILL, ST_INS_CHK, ST_INS_WALK, ST_INS_DEC, ST_SHR, ST_SHW,
      ST_INS_WR, ST_SCAN, ST_SCAN_END, ST_QDEC, ST_PSR, ST_PSW, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CAPTURE, OP_FILL_RD, OP_WALK_START, OP_WALK, OP_DECIDE,
      OP_SHIFT_RD, OP_SHIFT_WR, OP_WRITE, OP_SCAN, OP_SCAN_END, OP_QUERY,
      OP_PSH_RD, OP_PSH_WR, OP_RESULT
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic row_bad;
      logic fill_zero;
      logic walk_done;
      logic dec_stop;
      logic dec_shift;
      logic shw_more;
      logic scan_last;
      logic q_shift;
      logic psw_more;
      logic out_free;
   } stat_type;

   // true when cost a orders strictly ahead of cost b
   function automatic logic cost_before(input logic [23:0] af, input logic [23:0] ag,
                                        input logic [23:0] bf, input logic [23:0] bg,
                                        input logic mode);
      logic r;
      if (af == bf) r = mode ? (ag < bg) : (ag > bg);
      else r = (af < bf);
      return r;
   endfunction

endpackage

@@ hdl/bucketed_sorted_open_list_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_sorted_open_list_core
// Search open list kept as one f/g-sorted bucket per grid row.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   req_valid req_stall req_data  valid and not stall
//  response  rsp_valid rsp_stall rsp_data  valid and not stall
//  control   csr_valid csr_ready csr_data  valid and ready, tie-break mode
//
//  Insert: reads the bucket fill, walks k entries for the position and a
//  key match, shifts s entries up one slot and writes the new entry.
//  Peek/pop: head scan over all ROWS buckets; pop then shifts fill - 1 down.
//  One request at a time; a finished response waits in its output register.
//  Synchronous reset empties all buckets at once, no clearing pass.
// ----------------------------------------------------------------------------
module bucketed_sorted_open_list_core #(
   parameter int ROWS         = 256,
   parameter int BUCKET_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bsol_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bsol_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   bsol_pkg::ctl_type  ctl;
   bsol_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   bsol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   bsol_dpath #(
      .ROWS         (ROWS),
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl),
      .stat      (stat)
   );

endmodule

@@ hdl/bsol_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsol_ctrl
// Sequencer: steps insert walks, shifts and the head scan of peek and pop.
// ----------------------------------------------------------------------------
module bsol_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_cmd,
   output logic               req_stall,
   input  bsol_pkg::stat_type stat,
   output bsol_pkg::ctl_type  ctl
);

   bsol_pkg::state_type state_ff, state_in;
   logic accept;

   assign req_stall = (state_ff != bsol_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= bsol_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsol_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd) inside
                  bsol_pkg::CMD_INSERT: state_in = bsol_pkg::ST_INS_FILL;
                  bsol_pkg::CMD_PEEK, bsol_pkg::CMD_POP: state_in = bsol_pkg::ST_SCAN;
                  default: state_in = bsol_pkg::ST_IDLE;
               endcase
            end
         end
         bsol_pkg::ST_INS_FILL: state_in = bsol_pkg::ST_INS_CHK;
         bsol_pkg::ST_INS_CHK: begin
            if (stat.row_bad) state_in = bsol_pkg::ST_DONE;
            else if (stat.fill_zero) state_in = bsol_pkg::ST_INS_DEC;
            else state_in = bsol_pkg::ST_INS_WALK;
         end
         bsol_pkg::ST_INS_WALK: if (stat.walk_done) state_in = bsol_pkg::ST_INS_DEC;
         bsol_pkg::ST_INS_DEC: begin
            if (stat.dec_stop) state_in = bsol_pkg::ST_DONE;
            else if (stat.dec_shift) state_in = bsol_pkg::ST_SHR;
            else state_in = bsol_pkg::ST_INS_WR;
         end
         bsol_pkg::ST_SHR: state_in = bsol_pkg::ST_SHW;
         bsol_pkg::ST_SHW: state_in = stat.shw_more ? bsol_pkg::ST_SHR : bsol_pkg::ST_INS_WR;
         bsol_pkg::ST_INS_WR: state_in = bsol_pkg::ST_DONE;
         bsol_pkg::ST_SCAN: if (stat.scan_last) state_in = bsol_pkg::ST_SCAN_END;
         bsol_pkg::ST_SCAN_END: state_in = bsol_pkg::ST_QDEC;
         bsol_pkg::ST_QDEC: state_in = stat.q_shift ? bsol_pkg::ST_PSR : bsol_pkg::ST_DONE;
         bsol_pkg::ST_PSR: state_in = bsol_pkg::ST_PSW;
         bsol_pkg::ST_PSW: state_in = stat.psw_more ? bsol_pkg::ST_PSR : bsol_pkg::ST_DONE;
         bsol_pkg::ST_DONE: if (stat.out_free) state_in = bsol_pkg::ST_IDLE;
         default: state_in = bsol_pkg::ST_IDLE;
      endcase
   end

   // datapath command per state
   always_comb begin
      ctl.op = bsol_pkg::OP_NONE;
      unique case (state_ff)
         bsol_pkg::ST_IDLE:     if (accept) ctl.op = bsol_pkg::OP_CAPTURE;
         bsol_pkg::ST_INS_FILL: ctl.op = bsol_pkg::OP_FILL_RD;
         bsol_pkg::ST_INS_CHK:  ctl.op = bsol_pkg::OP_WALK_START;
         bsol_pkg::ST_INS_WALK: ctl.op = bsol_pkg::OP_WALK;
         bsol_pkg::ST_INS_DEC:  ctl.op = bsol_pkg::OP_DECIDE;
         bsol_pkg::ST_SHR:      ctl.op = bsol_pkg::OP_SHIFT_RD;
         bsol_pkg::ST_SHW:      ctl.op = bsol_pkg::OP_SHIFT_WR;
         bsol_pkg::ST_INS_WR:   ctl.op = bsol_pkg::OP_WRITE;
         bsol_pkg::ST_SCAN:     ctl.op = bsol_pkg::OP_SCAN;
         bsol_pkg::ST_SCAN_END: ctl.op = bsol_pkg::OP_SCAN_END;
         bsol_pkg::ST_QDEC:     ctl.op = bsol_pkg::OP_QUERY;
         bsol_pkg::ST_PSR:      ctl.op = bsol_pkg::OP_PSH_RD;
         bsol_pkg::ST_PSW:      ctl.op = bsol_pkg::OP_PSH_WR;
         bsol_pkg::ST_DONE:     if (stat.out_free) ctl.op = bsol_pkg::OP_RESULT;
         default:               ctl.op = bsol_pkg::OP_NONE;
      endcase
   end

endmodule

@@ hdl/bsol_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsol_dpath
// Entry and fill memories, walk and scan counters, result register.
// ----------------------------------------------------------------------------
module bsol_dpath #(
   parameter int ROWS         = 256,
   parameter int BUCKET_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  bsol_pkg::req_type  req_data,
   input  logic               csr_valid,
   input  logic               csr_data,
   output bsol_pkg::rsp_type  rsp_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  bsol_pkg::ctl_type  ctl,
   output bsol_pkg::stat_type stat
);

   localparam int RW = $clog2(ROWS);
   localparam int SW = $clog2(BUCKET_DEPTH);
   localparam int CW = $clog2(BUCKET_DEPTH + 1);
   localparam int AW = RW + SW;

   // storage
   bsol_pkg::ent_type ent_mem [1 << AW];
   logic [CW-1:0]     fill_mem [ROWS];
   logic [ROWS-1:0]   fill_vld_ff;

   bsol_pkg::req_type  req_ff;
   bsol_pkg::rsp_type  rsp_ff, rsp_in;
   bsol_pkg::ent_type  ent_rd_ff, best_ent_ff, new_ent;
   logic               mode_ff, rsp_valid_ff;
   logic [CW-1:0]      fill_rd_ff, n_ff, idx_ff, pos_ff, match_ff, best_fill_ff;
   logic               found_ff, mhit_ff;
   logic [23:0]        mf_ff;
   logic [2:0]         sts_ff;
   logic [bsol_pkg::COUNT_W-1:0] total_ff;
   logic [RW-1:0]      scan_row_ff, scan_prev_ff, best_row_ff;
   logic               scan_vld_ff, best_vld_ff;

   logic [RW+7:0]      row_wide, brow_wide;
   logic [RW-1:0]      row_idx, fill_ra, fill_wa;
   logic [CW-1:0]      fill_wd, idx_inc, idx_dec, hi;
   logic               fill_we, ent_we, row_bad, key_eq, cur_before;
   logic               reject, full, cand, have;
   logic [AW-1:0]      ent_ra, ent_wa;
   bsol_pkg::ent_type  ent_wd;

   assign row_wide = (RW + 8)'(req_ff.node_row);
   assign row_idx  = row_wide[RW-1:0];
   assign row_bad  = ({24'd0, req_ff.node_row} >= 32'(ROWS));
   assign idx_inc  = idx_ff + CW'(1);
   assign idx_dec  = idx_ff - CW'(1);

   assign new_ent = '{col: req_ff.node_col, layer: req_ff.node_layer,
                      prow: req_ff.parent_row, pcol: req_ff.parent_col,
                      player: req_ff.parent_layer, f: req_ff.f_cost, g: req_ff.g_cost,
                      aux: req_ff.aux_value, radius: req_ff.turn_radius};

   // walk compare on the entry just read
   assign key_eq = (ent_rd_ff.col == new_ent.col) && (ent_rd_ff.layer == new_ent.layer) &&
                   (ent_rd_ff.prow == new_ent.prow) && (ent_rd_ff.pcol == new_ent.pcol) &&
                   (ent_rd_ff.player == new_ent.player);
   assign cur_before = bsol_pkg::cost_before(ent_rd_ff.f, ent_rd_ff.g, new_ent.f, new_ent.g,
                                             mode_ff);

   // insert decision
   assign reject = mhit_ff && (new_ent.f >= mf_ff);
   assign full   = !mhit_ff && (n_ff >= CW'(BUCKET_DEPTH));
   assign hi     = mhit_ff ? match_ff : n_ff;

   // scan: a nonempty head that beats the current best
   assign cand = scan_vld_ff && (fill_rd_ff != '0) &&
                 (!best_vld_ff || bsol_pkg::cost_before(ent_rd_ff.f, ent_rd_ff.g,
                                                        best_ent_ff.f, best_ent_ff.g,
                                                        mode_ff));

   // status to sequencer
   always_comb begin
      stat.row_bad   = row_bad;
      stat.fill_zero = (fill_rd_ff == '0);
      stat.walk_done = key_eq || (idx_inc == n_ff);
      stat.dec_stop  = reject || full;
      stat.dec_shift = (hi > pos_ff);
      stat.shw_more  = (idx_dec > pos_ff);
      stat.scan_last = (scan_row_ff == RW'(ROWS - 1));
      stat.q_shift   = (req_ff.cmd == bsol_pkg::CMD_POP) && best_vld_ff &&
                       (best_fill_ff > CW'(1));
      stat.psw_more  = (idx_inc < best_fill_ff);
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // memory addressing
   always_comb begin
      fill_ra = row_idx;
      fill_we = 1'b0;
      fill_wa = row_idx;
      fill_wd = n_ff + CW'(1);
      ent_ra  = {row_idx, idx_ff[SW-1:0]};
      ent_we  = 1'b0;
      ent_wa  = {row_idx, idx_ff[SW-1:0]};
      ent_wd  = ent_rd_ff;
      case (ctl.op)
         bsol_pkg::OP_WALK_START: ent_ra = {row_idx, {SW{1'b0}}};
         bsol_pkg::OP_WALK:       ent_ra = {row_idx, idx_inc[SW-1:0]};
         bsol_pkg::OP_DECIDE:     fill_we = !reject && !full && !mhit_ff;
         bsol_pkg::OP_SHIFT_RD:   ent_ra = {row_idx, idx_dec[SW-1:0]};
         bsol_pkg::OP_SHIFT_WR:   ent_we = 1'b1;
         bsol_pkg::OP_WRITE: begin
            ent_we = 1'b1;
            ent_wa = {row_idx, pos_ff[SW-1:0]};
            ent_wd = new_ent;
         end
         bsol_pkg::OP_SCAN: begin
            fill_ra = scan_row_ff;
            ent_ra  = {scan_row_ff, {SW{1'b0}}};
         end
         bsol_pkg::OP_QUERY: begin
            fill_we = (req_ff.cmd == bsol_pkg::CMD_POP) && best_vld_ff;
            fill_wa = best_row_ff;
            fill_wd = best_fill_ff - CW'(1);
         end
         bsol_pkg::OP_PSH_RD: ent_ra = {best_row_ff, idx_ff[SW-1:0]};
         bsol_pkg::OP_PSH_WR: begin
            ent_we = 1'b1;
            ent_wa = {best_row_ff, idx_dec[SW-1:0]};
         end
         default: ;
      endcase
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_wa] <= ent_wd;
      ent_rd_ff <= ent_mem[ent_ra];
   end

   // fill memory, unwritten rows read as empty
   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[fill_wa] <= fill_wd;
      fill_rd_ff <= fill_vld_ff[fill_ra] ? fill_mem[fill_ra] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) fill_vld_ff <= '0;
      else if (fill_we) fill_vld_ff[fill_wa] <= 1'b1;
   end

   // mode register
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else if (csr_valid) mode_ff <= csr_data;
   end

   // control counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         scan_vld_ff <= 1'b0;
         best_vld_ff <= 1'b0;
         scan_row_ff <= '0;
      end else begin
         scan_vld_ff <= (ctl.op == bsol_pkg::OP_SCAN);
         if (ctl.op == bsol_pkg::OP_CAPTURE) begin
            scan_row_ff <= '0;
            best_vld_ff <= 1'b0;
         end
         if (ctl.op == bsol_pkg::OP_SCAN) scan_row_ff <= scan_row_ff + RW'(1);
         if (cand) best_vld_ff <= 1'b1;
         if (ctl.op == bsol_pkg::OP_DECIDE && !reject && !full && !mhit_ff)
            total_ff <= total_ff + bsol_pkg::COUNT_W'(1);
         if (ctl.op == bsol_pkg::OP_QUERY && req_ff.cmd == bsol_pkg::CMD_POP && best_vld_ff)
            total_ff <= total_ff - bsol_pkg::COUNT_W'(1);
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (ctl.op == bsol_pkg::OP_CAPTURE) req_ff <= req_data;
      if (ctl.op == bsol_pkg::OP_SCAN) scan_prev_ff <= scan_row_ff;
      if (cand) begin
         best_ent_ff  <= ent_rd_ff;
         best_row_ff  <= scan_prev_ff;
         best_fill_ff <= fill_rd_ff;
      end
      case (ctl.op)
         bsol_pkg::OP_WALK_START: begin
            n_ff     <= fill_rd_ff;
            idx_ff   <= '0;
            pos_ff   <= fill_rd_ff;
            match_ff <= fill_rd_ff;
            found_ff <= 1'b0;
            mhit_ff  <= 1'b0;
            sts_ff   <= bsol_pkg::STS_FULL;
         end
         bsol_pkg::OP_WALK: begin
            if (!found_ff && !cur_before) begin
               pos_ff   <= idx_ff;
               found_ff <= 1'b1;
            end
            if (key_eq) begin
               match_ff <= idx_ff;
               mhit_ff  <= 1'b1;
               mf_ff    <= ent_rd_ff.f;
            end
            idx_ff <= idx_inc;
         end
         bsol_pkg::OP_DECIDE: begin
            idx_ff <= hi;
            if (reject) sts_ff <= bsol_pkg::STS_REJECTED;
            else if (full) sts_ff <= bsol_pkg::STS_FULL;
            else sts_ff <= bsol_pkg::STS_INSERTED;
         end
         bsol_pkg::OP_SHIFT_WR: idx_ff <= idx_dec;
         bsol_pkg::OP_QUERY: begin
            idx_ff <= CW'(1);
            if (!best_vld_ff) sts_ff <= bsol_pkg::STS_EMPTY;
            else if (req_ff.cmd == bsol_pkg::CMD_POP) sts_ff <= bsol_pkg::STS_POPPED;
            else sts_ff <= bsol_pkg::STS_PEEKED;
         end
         bsol_pkg::OP_PSH_WR: idx_ff <= idx_inc;
         default: ;
      endcase
   end

   // result register
   assign have      = (sts_ff == bsol_pkg::STS_PEEKED) || (sts_ff == bsol_pkg::STS_POPPED);
   assign brow_wide = (RW + 8)'(best_row_ff);

   always_comb begin
      rsp_in = '0;
      rsp_in.status      = sts_ff;
      rsp_in.entry_count = total_ff;
      if (have) begin
         rsp_in.out_row          = brow_wide[7:0];
         rsp_in.out_col          = best_ent_ff.col;
         rsp_in.out_layer        = best_ent_ff.layer;
         rsp_in.out_parent_row   = best_ent_ff.prow;
         rsp_in.out_parent_col   = best_ent_ff.pcol;
         rsp_in.out_parent_layer = best_ent_ff.player;
         rsp_in.out_f            = best_ent_ff.f;
         rsp_in.out_g            = best_ent_ff.g;
         rsp_in.out_aux          = best_ent_ff.aux;
         rsp_in.out_radius       = best_ent_ff.radius;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == bsol_pkg::OP_RESULT) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (ctl.op == bsol_pkg::OP_RESULT) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // checks
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == bsol_pkg::OP_WALK) |-> (idx_ff < n_ff))
      else $error("walk index past bucket fill");

   a_pos_le_fill: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == bsol_pkg::OP_DECIDE) |-> (pos_ff <= n_ff))
      else $error("insert position beyond fill");

   a_found_result: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == bsol_pkg::OP_RESULT && have) |-> best_vld_ff)
      else $error("minimum reported without a valid head");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == bsol_pkg::OP_PSH_WR) |-> (best_fill_ff > CW'(1)))
      else $error("pop shift on a single entry bucket");

endmodule
